@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the battery fault monitor RTL.
// Each macro checks on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bfm_pkg.sv @@
// Package for the battery fault monitor: widths, register indexes, reset values and types.
// Used by bfm_eval and battery_fault_monitor_unit; depends on nothing else.
package bfm_pkg;

  localparam int SKIP_TICKS_DEF      = 10;
  localparam int OT_TICKS_DEF        = 2;
  localparam int WARN_UNDER_TEMP_DEF = 0;
  localparam int WARN_OVER_MA_DEF    = 150000;

  localparam int MV_W        = 16;
  localparam int TEMP_W      = 12;
  localparam int CUR_W       = 22;
  localparam int MA_W        = 21;
  localparam int FLAG_W      = 5;
  localparam int STARTUP_W   = 4;
  localparam int OT_CNT_W    = 2;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 21;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 16;

  localparam int FLAG_UV = 0;
  localparam int FLAG_OV = 1;
  localparam int FLAG_UT = 2;
  localparam int FLAG_OT = 3;
  localparam int FLAG_OC = 4;

  localparam logic [MV_W-1:0]          WARN_UNDER_MV_RST  = 16'd3000;
  localparam logic [MV_W-1:0]          WARN_OVER_MV_RST   = 16'd4150;
  localparam logic signed [TEMP_W-1:0] WARN_OVER_TEMP_RST = 12'sd500;
  localparam logic [MV_W-1:0]          ERR_UNDER_MV_RST   = 16'd2800;
  localparam logic [MV_W-1:0]          ERR_OVER_MV_RST    = 16'd4250;
  localparam logic signed [TEMP_W-1:0] ERR_UNDER_TEMP_RST = -12'sd200;
  localparam logic signed [TEMP_W-1:0] ERR_OVER_TEMP_RST  = 12'sd600;
  localparam logic [MA_W-1:0]          ERR_OVER_MA_RST    = 21'd200000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WARN_UNDER_MV  = 3'd0,
    REG_WARN_OVER_MV   = 3'd1,
    REG_WARN_OVER_TEMP = 3'd2,
    REG_ERR_UNDER_MV   = 3'd3,
    REG_ERR_OVER_MV    = 3'd4,
    REG_ERR_UNDER_TEMP = 3'd5,
    REG_ERR_OVER_TEMP  = 3'd6,
    REG_ERR_OVER_MA    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [MV_W-1:0]          warn_under_mv;
    logic [MV_W-1:0]          warn_over_mv;
    logic signed [TEMP_W-1:0] warn_over_temp;
    logic [MV_W-1:0]          err_under_mv;
    logic [MV_W-1:0]          err_over_mv;
    logic signed [TEMP_W-1:0] err_under_temp;
    logic signed [TEMP_W-1:0] err_over_temp;
    logic [MA_W-1:0]          err_over_ma;
  } cfg_t;

  typedef struct packed {
    logic [MV_W-1:0]          min_cell_mv;
    logic [MV_W-1:0]          max_cell_mv;
    logic signed [TEMP_W-1:0] min_temp;
    logic signed [TEMP_W-1:0] max_temp;
    logic signed [CUR_W-1:0]  pack_current_ma;
  } sample_t;

  typedef struct packed {
    logic [STARTUP_W-1:0] startup_ticks;
    logic [OT_CNT_W-1:0]  over_temp_ticks;
    logic [FLAG_W-1:0]    error_latch;
  } mon_state_t;

  typedef struct packed {
    logic [FLAG_W-1:0] warning_bits;
    logic              any_warning;
    logic [FLAG_W-1:0] error_bits;
    logic              any_error;
    logic              relay_closed;
    logic              blanking;
  } result_t;

endpackage

@@ rtl/core/bfm_eval.sv @@
// Per-tick evaluation: threshold compares, blanking, overtemperature count and error latch update.
// Purely combinational; uses types and constants from bfm_pkg.
module bfm_eval import bfm_pkg::*; #(
  parameter int SKIP_TICKS      = SKIP_TICKS_DEF,
  parameter int OT_TICKS        = OT_TICKS_DEF,
  parameter int WARN_UNDER_TEMP = WARN_UNDER_TEMP_DEF,
  parameter int WARN_OVER_MA    = WARN_OVER_MA_DEF
) (
  input  sample_t    sample,
  input  cfg_t       cfg,
  input  mon_state_t state,
  output mon_state_t state_next,
  output result_t    res
);

  logic [CUR_W-1:0]    mag;
  logic [FLAG_W-1:0]   warn;
  logic [FLAG_W-1:0]   err_hit;
  logic                blank;
  logic                ot_hit;
  logic [OT_CNT_W-1:0] ot_next;

  // The magnitude of the most negative current still fits as an unsigned value.
  assign mag = sample.pack_current_ma[CUR_W-1] ? (~sample.pack_current_ma + 1'b1)
                                               : sample.pack_current_ma;

  always_comb begin
    warn          = '0;
    warn[FLAG_UV] = sample.min_cell_mv < cfg.warn_under_mv;
    warn[FLAG_OV] = sample.max_cell_mv > cfg.warn_over_mv;
    warn[FLAG_UT] = $signed(sample.min_temp) < $signed(TEMP_W'(WARN_UNDER_TEMP));
    warn[FLAG_OT] = $signed(sample.max_temp) > $signed(cfg.warn_over_temp);
    warn[FLAG_OC] = mag > CUR_W'(WARN_OVER_MA);
  end

  assign blank  = state.startup_ticks <= STARTUP_W'(SKIP_TICKS);
  assign ot_hit = $signed(sample.max_temp) > $signed(cfg.err_over_temp);

  always_comb begin
    if (!ot_hit) begin
      ot_next = '0;
    end else if (state.over_temp_ticks < OT_CNT_W'(OT_TICKS)) begin
      ot_next = state.over_temp_ticks + 1'b1;
    end else begin
      ot_next = state.over_temp_ticks;
    end
  end

  always_comb begin
    err_hit          = '0;
    err_hit[FLAG_UV] = sample.min_cell_mv < cfg.err_under_mv;
    err_hit[FLAG_OV] = sample.max_cell_mv > cfg.err_over_mv;
    err_hit[FLAG_UT] = $signed(sample.min_temp) < $signed(cfg.err_under_temp);
    err_hit[FLAG_OT] = ot_next >= OT_CNT_W'(OT_TICKS);
    err_hit[FLAG_OC] = mag > {1'b0, cfg.err_over_ma};
  end

  always_comb begin
    state_next = state;
    if (blank) begin
      state_next.startup_ticks = state.startup_ticks + 1'b1;
    end else begin
      state_next.over_temp_ticks = ot_next;
      state_next.error_latch     = state.error_latch | err_hit;
    end
  end

  always_comb begin
    res.warning_bits = warn;
    res.any_warning  = |warn;
    res.error_bits   = state_next.error_latch;
    res.any_error    = |state_next.error_latch;
    res.relay_closed = !blank && !(|state_next.error_latch);
    res.blanking     = blank;
  end

endmodule

@@ rtl/core/battery_fault_monitor_unit.sv @@
// Top level of the battery fault monitor: stream ports, input and result registers,
// configuration registers and monitor state. Depends on bfm_pkg, bfm_eval, assert_macros.svh.
//
//   channel | dir | handshake         | payload
//   s       | in  | s_tvalid/s_tready | s_tdata: one monitoring tick
//   m       | out | m_tvalid/m_tready | m_tdata: one status result per tick
//   cfg     | in  | cfg_we            | cfg_addr, cfg_data
//
// While m is not stalled, one tick is accepted per clock; its result is presented when it
// moves from the input register into the result register.
// A single evaluation stage lies between those two registers.
// Reset clears the valid flags, the monitor state and the thresholds to their defaults.
// A stall on m holds the result; the input register takes one more tick only if it is
// empty, and s_tready stays low after that until the result is taken.
`include "assert_macros.svh"

module battery_fault_monitor_unit import bfm_pkg::*; #(
  parameter int SKIP_TICKS      = SKIP_TICKS_DEF,
  parameter int OT_TICKS        = OT_TICKS_DEF,
  parameter int WARN_UNDER_TEMP = WARN_UNDER_TEMP_DEF,
  parameter int WARN_OVER_MA    = WARN_OVER_MA_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // min_cell_mv, max_cell_mv, min_temp, max_temp, pack_current_ma, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // warning_bits, any_warning, error_bits, any_error, relay_closed, blanking, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic       in_valid;
  sample_t    in_sample;
  sample_t    s_sample;
  logic       advance;
  cfg_t       cfg;
  mon_state_t state;
  mon_state_t state_next;
  result_t    res_next;
  result_t    res;

  assign s_sample.min_cell_mv     = s_tdata[15:0];
  assign s_sample.max_cell_mv     = s_tdata[31:16];
  assign s_sample.min_temp        = s_tdata[43:32];
  assign s_sample.max_temp        = s_tdata[55:44];
  assign s_sample.pack_current_ma = s_tdata[77:56];

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn_under_mv  <= WARN_UNDER_MV_RST;
      cfg.warn_over_mv   <= WARN_OVER_MV_RST;
      cfg.warn_over_temp <= WARN_OVER_TEMP_RST;
      cfg.err_under_mv   <= ERR_UNDER_MV_RST;
      cfg.err_over_mv    <= ERR_OVER_MV_RST;
      cfg.err_under_temp <= ERR_UNDER_TEMP_RST;
      cfg.err_over_temp  <= ERR_OVER_TEMP_RST;
      cfg.err_over_ma    <= ERR_OVER_MA_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_WARN_UNDER_MV:  cfg.warn_under_mv  <= cfg_data[MV_W-1:0];
        REG_WARN_OVER_MV:   cfg.warn_over_mv   <= cfg_data[MV_W-1:0];
        REG_WARN_OVER_TEMP: cfg.warn_over_temp <= cfg_data[TEMP_W-1:0];
        REG_ERR_UNDER_MV:   cfg.err_under_mv   <= cfg_data[MV_W-1:0];
        REG_ERR_OVER_MV:    cfg.err_over_mv    <= cfg_data[MV_W-1:0];
        REG_ERR_UNDER_TEMP: cfg.err_under_temp <= cfg_data[TEMP_W-1:0];
        REG_ERR_OVER_TEMP:  cfg.err_over_temp  <= cfg_data[TEMP_W-1:0];
        REG_ERR_OVER_MA:    cfg.err_over_ma    <= cfg_data[MA_W-1:0];
        default: ;
      endcase
    end
  end

  bfm_eval #(
    .SKIP_TICKS      (SKIP_TICKS),
    .OT_TICKS        (OT_TICKS),
    .WARN_UNDER_TEMP (WARN_UNDER_TEMP),
    .WARN_OVER_MA    (WARN_OVER_MA)
  ) u_eval (
    .sample     (in_sample),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {2'b00, res.blanking, res.relay_closed, res.any_error, res.error_bits,
                    res.any_warning, res.warning_bits};

  `ASSERT_NEXT(a_latch_sticky, 1'b1,
    (state.error_latch & $past(state.error_latch)) == $past(state.error_latch),
    "latched error bit cleared without reset")
  `ASSERT_NEXT(a_state_hold, !advance, $stable(state),
    "monitor state changed without a request moving")
  `ASSERT_IMPLIES(a_blank_relay, m_tvalid && res.blanking, !res.relay_closed,
    "relay closed during blanking")
  `ASSERT_IMPLIES(a_startup_bound, 1'b1, state.startup_ticks <= STARTUP_W'(SKIP_TICKS + 1),
    "startup count ran past the blanking end")

endmodule

@@ tb/bfm_status_checker.sv @@
// Checker for the battery fault monitor: watches the tick, status and threshold ports,
// predicts each status result from its own copy of thresholds and monitor state, and compares.
// Depends on bfm_pkg for field widths, register indexes and reset thresholds.
module bfm_status_checker import bfm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     pending,
  output int                     mismatches,
  output int                     ticks_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                 limits;
  logic [STARTUP_W-1:0] warmup;
  logic [OT_CNT_W-1:0]  hot_run;
  logic [FLAG_W-1:0]    fault_latch;
  logic                 fault_any;
  result_t              expected_status[$];

  function automatic sample_t unpack_tick(logic [IN_TDATA_W-1:0] bus);
    sample_t smp;
    smp.min_cell_mv     = bus[0 +: MV_W];
    smp.max_cell_mv     = bus[MV_W +: MV_W];
    smp.min_temp        = bus[2*MV_W +: TEMP_W];
    smp.max_temp        = bus[2*MV_W+TEMP_W +: TEMP_W];
    smp.pack_current_ma = bus[2*MV_W+2*TEMP_W +: CUR_W];
    return smp;
  endfunction

  // Advances the monitor state by one tick and returns the status it reports.
  function automatic result_t judge_tick(sample_t smp);
    result_t r;
    int      vmin, vmax, tmin, tmax, cur, mag;
    logic    blank;
    vmin = smp.min_cell_mv;
    vmax = smp.max_cell_mv;
    tmin = $signed(smp.min_temp);
    tmax = $signed(smp.max_temp);
    cur  = $signed(smp.pack_current_ma);
    mag  = (cur < 0) ? -cur : cur;
    r = '0;
    r.warning_bits[FLAG_UV] = vmin < int'(limits.warn_under_mv);
    r.warning_bits[FLAG_OV] = vmax > int'(limits.warn_over_mv);
    r.warning_bits[FLAG_UT] = tmin < WARN_UNDER_TEMP_DEF;
    r.warning_bits[FLAG_OT] = tmax > int'($signed(limits.warn_over_temp));
    r.warning_bits[FLAG_OC] = mag > WARN_OVER_MA_DEF;

    blank = warmup <= SKIP_TICKS_DEF;
    if (blank) begin
      warmup = warmup + 1'b1;
    end else begin
      if (tmax > int'($signed(limits.err_over_temp))) begin
        if (hot_run < OT_TICKS_DEF) hot_run = hot_run + 1'b1;
      end else begin
        hot_run = '0;
      end
      if (vmin < int'(limits.err_under_mv)) fault_latch[FLAG_UV] = 1'b1;
      if (vmax > int'(limits.err_over_mv)) fault_latch[FLAG_OV] = 1'b1;
      if (tmin < int'($signed(limits.err_under_temp))) fault_latch[FLAG_UT] = 1'b1;
      if (hot_run >= OT_TICKS_DEF) fault_latch[FLAG_OT] = 1'b1;
      if (mag > int'(limits.err_over_ma)) fault_latch[FLAG_OC] = 1'b1;
      fault_any = |fault_latch;
    end

    r.any_warning  = |r.warning_bits;
    r.error_bits   = fault_latch;
    r.any_error    = fault_any;
    r.relay_closed = !blank && !fault_any;
    r.blanking     = blank;
    return r;
  endfunction

  task automatic compare_status(result_t want, logic [OUT_TDATA_W-1:0] bus);
    string names[6] = '{"warning_bits", "any_warning", "error_bits", "any_error",
                        "relay_closed", "blanking"};
    int    want_f[6];
    int    got_f[6];
    want_f = '{want.warning_bits, want.any_warning, want.error_bits, want.any_error,
               want.relay_closed, want.blanking};
    got_f  = '{bus[0 +: FLAG_W], bus[FLAG_W], bus[FLAG_W+1 +: FLAG_W], bus[2*FLAG_W+1],
               bus[2*FLAG_W+2], bus[2*FLAG_W+3]};
    for (int i = 0; i < 6; i++) begin
      if (want_f[i] != got_f[i]) begin
        $error("%s: expected %0d, got %0d", names[i], want_f[i], got_f[i]);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      limits = '{WARN_UNDER_MV_RST, WARN_OVER_MV_RST, WARN_OVER_TEMP_RST, ERR_UNDER_MV_RST,
                 ERR_OVER_MV_RST, ERR_UNDER_TEMP_RST, ERR_OVER_TEMP_RST, ERR_OVER_MA_RST};
      warmup      = '0;
      hot_run     = '0;
      fault_latch = '0;
      fault_any   = 1'b0;
      expected_status.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_WARN_UNDER_MV:  limits.warn_under_mv  = cfg_data[MV_W-1:0];
          REG_WARN_OVER_MV:   limits.warn_over_mv   = cfg_data[MV_W-1:0];
          REG_WARN_OVER_TEMP: limits.warn_over_temp = cfg_data[TEMP_W-1:0];
          REG_ERR_UNDER_MV:   limits.err_under_mv   = cfg_data[MV_W-1:0];
          REG_ERR_OVER_MV:    limits.err_over_mv    = cfg_data[MV_W-1:0];
          REG_ERR_UNDER_TEMP: limits.err_under_temp = cfg_data[TEMP_W-1:0];
          REG_ERR_OVER_TEMP:  limits.err_over_temp  = cfg_data[TEMP_W-1:0];
          REG_ERR_OVER_MA:    limits.err_over_ma    = cfg_data[MA_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expected_status.push_back(judge_tick(unpack_tick(s_tdata)));
      if (m_tvalid && m_tready) begin
        ticks_seen++;
        if (expected_status.size() == 0) begin
          $error("status result with no request pending: %h", m_tdata);
          mismatches++;
        end else begin
          compare_status(expected_status.pop_front(), m_tdata);
        end
      end
      pending <= expected_status.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// Top of the battery fault monitor testbench: clock, reset, tick stimulus, threshold
// writes and output back-pressure. Depends on bfm_pkg, bfm_status_checker and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bfm_pkg::*;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we   = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     pending;
  int                     mismatches;
  int                     ticks_seen;
  logic                   calm     = 1'b0;
  logic                   hold_req = 1'b0;
  logic                   oc_armed = 1'b0;
  int                     sent     = 0;
  cfg_t                   cfg_now  = '{WARN_UNDER_MV_RST, WARN_OVER_MV_RST, WARN_OVER_TEMP_RST,
                                       ERR_UNDER_MV_RST, ERR_OVER_MV_RST, ERR_UNDER_TEMP_RST,
                                       ERR_OVER_TEMP_RST, ERR_OVER_MA_RST};

  battery_fault_monitor_unit DUT (.*);
  bfm_status_checker watcher (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Output side: random stalls, one long hold-off on request, none while calm.
  initial begin : sink
    int   hold_left;
    logic held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 18);
      end
    end
  end

  task automatic send_tick(int vmin, int vmax, int tmin, int tmax, int cur);
    while (!calm && $urandom_range(0, 99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, CUR_W'(cur), TEMP_W'(tmax), TEMP_W'(tmin), MV_W'(vmax), MV_W'(vmin)};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_limit(cfg_reg_t idx, int value);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    case (idx)
      REG_WARN_UNDER_MV:  cfg_now.warn_under_mv  = MV_W'(value);
      REG_WARN_OVER_MV:   cfg_now.warn_over_mv   = MV_W'(value);
      REG_WARN_OVER_TEMP: cfg_now.warn_over_temp = TEMP_W'(value);
      REG_ERR_UNDER_MV:   cfg_now.err_under_mv   = MV_W'(value);
      REG_ERR_OVER_MV:    cfg_now.err_over_mv    = MV_W'(value);
      REG_ERR_UNDER_TEMP: cfg_now.err_under_temp = TEMP_W'(value);
      REG_ERR_OVER_TEMP:  cfg_now.err_over_temp  = TEMP_W'(value);
      REG_ERR_OVER_MA:    cfg_now.err_over_ma    = MA_W'(value);
      default: ;
    endcase
  endtask

  task automatic set_limits(int wuv, int wov, int wot, int euv, int eov, int eut, int eot,
                            int eoc);
    write_limit(REG_WARN_UNDER_MV, wuv);
    write_limit(REG_WARN_OVER_MV, wov);
    write_limit(REG_WARN_OVER_TEMP, wot);
    write_limit(REG_ERR_UNDER_MV, euv);
    write_limit(REG_ERR_OVER_MV, eov);
    write_limit(REG_ERR_UNDER_TEMP, eut);
    write_limit(REG_ERR_OVER_TEMP, eot);
    write_limit(REG_ERR_OVER_MA, eoc);
    cfg_we <= 1'b0;
  endtask

  function automatic int near(int anchor);
    return anchor + $urandom_range(0, 8) - 4;
  endfunction

  function automatic int pick_mv(int a, int b);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535);
      1: return near(a);
      2: return near(b);
      default: return $urandom_range(2500, 4500);
    endcase
  endfunction

  function automatic int pick_temp(int a, int b);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 4095);
      1: return near(a);
      2: return near(b);
      default: return $urandom_range(0, 1900) - 400;
    endcase
  endfunction

  function automatic int pick_current();
    int sign;
    int cur;
    sign = $urandom_range(0, 1) ? -1 : 1;
    case ($urandom_range(0, 3))
      0: cur = $urandom_range(0, 4194303);
      1: cur = sign * near(WARN_OVER_MA_DEF);
      2: cur = sign * near(int'(cfg_now.err_over_ma));
      default: cur = $urandom_range(0, 4000000) - 2000000;
    endcase
    // The most negative current exceeds even the largest overcurrent limit.
    if (!oc_armed && CUR_W'(cur) == {1'b1, {(CUR_W-1){1'b0}}}) cur = cur + 1;
    return cur;
  endfunction

  initial begin : stimulus
    int wuv, wov, wot, euv, eov, eut, eot, eoc;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Startup blanking: extremes pass without latching anything.
    send_tick(0, 65535, -2048, 2047, -2097152);
    send_tick(65535, 0, 2047, -2048, 2097151);
    send_tick(0, 0, -400, 1500, 2000000);
    send_tick(65535, 65535, 1500, -400, -2000000);
    send_tick(3000, 4150, 0, 500, 150000);
    send_tick(2999, 4151, -1, 501, -150001);
    for (int i = 0; i < 5; i++) send_tick(3700, 3800, 250, 700, i - 2);
    // Overtemperature runs that break before the count fills.
    send_tick(3700, 3800, 250, 700, 0);
    send_tick(3700, 3800, 250, 600, 0);
    send_tick(3700, 3800, 250, 601, 0);
    send_tick(3700, 3800, 250, 300, 0);
    // Values sitting exactly on the error and warning limits.
    send_tick(2800, 4250, -200, 600, 200000);
    send_tick(2800, 4250, -200, 600, -200000);
    send_tick(3700, 3800, 0, 300, 150000);
    send_tick(3700, 3800, 250, 300, -150000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      wuv = (ph == 0) ? 0 : (ph == 1) ? 65535 : $urandom_range(2500, 4500);
      wov = (ph == 0) ? 65535 : (ph == 1) ? 0 : $urandom_range(3000, 5000);
      wot = (ph == 0) ? 1500 : (ph == 1) ? -400 : (ph == 2) ? 2047 : (ph == 3) ? -2048 :
            $urandom_range(0, 1900) - 400;
      // Error limits stay out of reach until their phase, then each flag latches in turn.
      euv = (ph >= 3) ? $urandom_range(2000, 4000) : 0;
      eot = (ph >= 4) ? $urandom_range(0, 1900) - 400 : 2047;
      eov = (ph >= 5) ? $urandom_range(3000, 5000) : 65535;
      eut = (ph >= 6) ? $urandom_range(0, 1900) - 400 : -2048;
      eoc = (ph >= 7) ? $urandom_range(0, 2000000) : 2097151;
      oc_armed = (ph >= 7);
      calm <= (ph == 1);
      set_limits(wuv, wov, wot, euv, eov, eut, eot, eoc);
      for (int k = 0; k < 85; k++) begin
        if (ph == 2 && k == 10) hold_req <= 1'b1;
        send_tick(pick_mv(cfg_now.warn_under_mv, cfg_now.err_under_mv),
                  pick_mv(cfg_now.warn_over_mv, cfg_now.err_over_mv),
                  pick_temp(WARN_UNDER_TEMP_DEF, $signed(cfg_now.err_under_temp)),
                  pick_temp($signed(cfg_now.warn_over_temp), $signed(cfg_now.err_over_temp)),
                  pick_current());
      end
      drain();
    end

    repeat (4) @(posedge clk);
    $display("Checked %0d status results for %0d ticks under nine threshold settings,",
             ticks_seen, sent);
    $display("through startup blanking, every warning, each error latching and a long stall.");
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
